/* hdl/coema_pkg.sv */
package coema_pkg;

    // Width of the raw millisecond counter and of the wrap count above it.
    localparam int unsigned WordBits = 32;
    localparam int unsigned TimeBits = 2 * WordBits;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_LIMIT     = 2'd1,
        CFG_SHIFT     = 2'd2
    } t_cfg_index;

    // Reset values of the configuration registers.
    localparam logic [31:0] ThresholdReset = 32'd1000;
    localparam logic [7:0]  LimitReset     = 8'd5;
    localparam logic [4:0]  ShiftReset     = 5'd3;

    // Classification of what happened to the sample of one request.
    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_FIRST  = 3'd1,
        CLS_SMOOTH = 3'd2,
        CLS_REJECT = 3'd3,
        CLS_RESYNC = 3'd4
    } t_sample_class;

    typedef struct packed {
        logic [31:0] threshold;
        logic [7:0]  limit;
        logic [4:0]  shift;
    } t_cfg;

    typedef struct packed {
        logic                       action;
        logic [WordBits-1:0]        millis_now;
        logic signed [TimeBits-1:0] server_epoch;
    } t_item;

    typedef struct packed {
        logic signed [TimeBits-1:0] synced_time;
        t_sample_class              sample_class;
        logic                       is_synced;
    } t_result;

endpackage

/* hdl/coema_req_if.sv */
interface coema_req_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        action;
    logic [coema_pkg::WordBits-1:0]              millis_now;
    logic signed [coema_pkg::TimeBits-1:0]       server_epoch;

    modport source (output valid, action, millis_now, server_epoch, input ready);
    modport sink   (input valid, action, millis_now, server_epoch, output ready);
endinterface

/* hdl/coema_res_if.sv */
interface coema_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [coema_pkg::TimeBits-1:0] synced_time;
    logic [2:0]                            sample_class;
    logic                                  is_synced;

    modport source (output valid, synced_time, sample_class, is_synced, input ready);
    modport sink   (input valid, synced_time, sample_class, is_synced, output ready);
endinterface

/* hdl/coema_cfg_if.sv */
interface coema_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/clock_offset_ema_filter.sv */
// Channel   Dir  Modport  Payload
// i_req     in   sink     action, millis_now, server_epoch
// o_res     out  source   synced_time, sample_class, is_synced
// i_cfg     in   sink     index, data (register write, always ready)
//
// One request is accepted every cycle while ready is high; its result is held
// in the input register and then in the result register. The filter works on
// the input register and its state updates at the edge that loads the result
// register. A stalled result holds the result register and then the input
// register, so ready falls only when both are full.
// Reset is synchronous and active low; it loads the register defaults and
// clears the filter state and both valid flags.
module clock_offset_ema_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    coema_req_if.sink  i_req,
    coema_res_if.source o_res,
    coema_cfg_if.sink  i_cfg
);

    coema_pkg::t_cfg    cfg;
    coema_pkg::t_item   r_in_item;
    logic               r_in_valid;
    coema_pkg::t_result r_out;
    logic               r_out_valid;
    coema_pkg::t_result result;
    logic               step;

    coema_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    coema_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // The held request moves on when the result register is free or emptying.
    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item.action       <= i_req.action;
            r_in_item.millis_now   <= i_req.millis_now;
            r_in_item.server_epoch <= i_req.server_epoch;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.synced_time  = r_out.synced_time;
    assign o_res.sample_class = r_out.sample_class;
    assign o_res.is_synced    = r_out.is_synced;

    // Any real sample class implies the filter is synchronised.
    a_class_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.sample_class != coema_pkg::CLS_NONE)) |-> o_res.is_synced)
        else $error("sample class without sync");

    // With both registers full and the result stalled, no request is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |-> !i_req.ready)
        else $error("request taken while stalled");

    // An accepted request is held in the input register in the next cycle.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_in_valid)
        else $error("accepted request lost");

endmodule

/* hdl/coema_cfg.sv */
module coema_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    coema_cfg_if.sink          i_cfg,
    output coema_pkg::t_cfg    o_cfg
);

    coema_pkg::t_cfg r_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= coema_pkg::ThresholdReset;
            r_cfg.limit     <= coema_pkg::LimitReset;
            r_cfg.shift     <= coema_pkg::ShiftReset;
        end else if (i_cfg.valid) begin
            case (coema_pkg::t_cfg_index'(i_cfg.index))
                coema_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg.data;
                coema_pkg::CFG_LIMIT:     r_cfg.limit     <= i_cfg.data[7:0];
                coema_pkg::CFG_SHIFT:     r_cfg.shift     <= i_cfg.data[4:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/coema_filter.sv */
module coema_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  coema_pkg::t_cfg      i_cfg,
    input  logic                 i_step,
    input  coema_pkg::t_item     i_item,
    output coema_pkg::t_result   o_result
);

    localparam int unsigned W = coema_pkg::WordBits;
    localparam int unsigned T = coema_pkg::TimeBits;

    logic [W-1:0]  r_last, n_last;
    logic [W-1:0]  r_wrap, n_wrap;
    logic [T-1:0]  r_offset, n_offset;
    logic          r_synced, n_synced;
    logic [7:0]    r_run, n_run;

    logic [T-1:0]  local_ms;
    logic [T-1:0]  sample;
    logic [T-1:0]  diff;
    logic [T-1:0]  mag;
    logic [T-1:0]  step_ms;
    logic [7:0]    run_inc;
    logic          outlier;
    coema_pkg::t_sample_class cls;

    // Extend the counter reading: a lower reading than the last means a wrap.
    always_comb begin
        n_last   = i_item.millis_now;
        n_wrap   = r_wrap + {{(W-1){1'b0}}, (i_item.millis_now < r_last)};
        local_ms = {n_wrap, i_item.millis_now};
    end

    // Sample, its distance from the offset and the smoothing step.
    always_comb begin
        sample  = i_item.server_epoch - local_ms;
        diff    = sample - r_offset;
        mag     = diff[T-1] ? (~diff + {{(T-1){1'b0}}, 1'b1}) : diff;
        outlier = mag > {{(T-W){1'b0}}, i_cfg.threshold};
        step_ms = T'($signed(diff) >>> i_cfg.shift);
        run_inc = r_run + 8'd1;
    end

    // Filter decision.
    always_comb begin
        n_offset = r_offset;
        n_synced = r_synced;
        n_run    = r_run;
        cls      = coema_pkg::CLS_NONE;
        if (i_item.action) begin
            if (!r_synced) begin
                n_offset = sample;
                n_synced = 1'b1;
                n_run    = 8'd0;
                cls      = coema_pkg::CLS_FIRST;
            end else if (outlier) begin
                if (run_inc < i_cfg.limit) begin
                    n_run = run_inc;
                    cls   = coema_pkg::CLS_REJECT;
                end else begin
                    n_offset = sample;
                    n_run    = 8'd0;
                    cls      = coema_pkg::CLS_RESYNC;
                end
            end else begin
                n_offset = r_offset + step_ms;
                n_run    = 8'd0;
                cls      = coema_pkg::CLS_SMOOTH;
            end
        end
    end

    always_comb begin
        o_result.synced_time  = n_offset + local_ms;
        o_result.sample_class = cls;
        o_result.is_synced    = n_synced;
    end

    // Filter state advances with each request that moves to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_wrap   <= '0;
            r_offset <= '0;
            r_synced <= 1'b0;
            r_run    <= '0;
        end else if (i_step) begin
            r_last   <= n_last;
            r_wrap   <= n_wrap;
            r_offset <= n_offset;
            r_synced <= n_synced;
            r_run    <= n_run;
        end
    end

endmodule

/* tb/tb_clock_offset_ema_filter.sv */
module tb_clock_offset_ema_filter;

    logic i_clk = 1'b0;
    logic i_rst_n;

    coema_req_if req_ch();
    coema_res_if res_ch();
    coema_cfg_if cfg_ch();

    clock_offset_ema_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Free-running clock, period 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be driven and results owed by the filter.
    coema_pkg::t_item   req_backlog[$];
    coema_pkg::t_result results_due[$];

    // Own copy of the filter: register settings and state.
    coema_pkg::t_cfg filt_cfg;
    logic [31:0] prev_millis;
    logic [31:0] wraps;
    logic [63:0] filt_offset;
    logic        locked;
    logic [7:0]  miss_run;

    // Shadow of the local clock and of the server's true offset, used to
    // build plausible server messages ahead of time.
    logic [31:0] gen_millis;
    logic [31:0] gen_wraps;
    logic [31:0] gen_thr;
    logic [63:0] gen_true;

    int gap_pct = 0;
    int stall_pct = 0;
    int items_popped = 0;
    int results_seen = 0;
    int err_cnt = 0;
    int writes_done = 0;
    int cls_seen[5];

    // Advances the filter by one request and returns the result it owes.
    function automatic coema_pkg::t_result track_offset(coema_pkg::t_item it);
        logic [63:0]             stamp;
        logic [63:0]             sample;
        logic [63:0]             diff;
        logic [63:0]             mag;
        logic signed [63:0]      nudge;
        coema_pkg::t_sample_class cls;
        coema_pkg::t_result      res;
        cls = coema_pkg::CLS_NONE;
        if (it.millis_now < prev_millis) begin
            wraps = wraps + 32'd1;
        end
        prev_millis = it.millis_now;
        stamp = {wraps, it.millis_now};
        if (it.action) begin
            sample = it.server_epoch - stamp;
            if (!locked) begin
                filt_offset = sample;
                locked = 1'b1;
                miss_run = 8'd0;
                cls = coema_pkg::CLS_FIRST;
            end else begin
                diff = sample - filt_offset;
                // The most negative difference keeps its own bit pattern, so it
                // reads as 2^63 and is always too far away.
                mag = diff[63] ? -diff : diff;
                if (mag > {32'd0, filt_cfg.threshold}) begin
                    miss_run = miss_run + 8'd1;
                    if (miss_run < filt_cfg.limit) begin
                        cls = coema_pkg::CLS_REJECT;
                    end else begin
                        filt_offset = sample;
                        miss_run = 8'd0;
                        cls = coema_pkg::CLS_RESYNC;
                    end
                end else begin
                    nudge = $signed(diff) >>> filt_cfg.shift;
                    filt_offset = filt_offset + nudge;
                    miss_run = 8'd0;
                    cls = coema_pkg::CLS_SMOOTH;
                end
            end
        end
        res.synced_time = filt_offset + stamp;
        res.sample_class = cls;
        res.is_synced = locked;
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (err_cnt < 40) begin
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        end
        err_cnt++;
    endtask

    // Request driver: predicts each accepted request and offers the next one.
    always @(posedge i_clk) begin
        coema_pkg::t_item   nxt;
        coema_pkg::t_result due;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                due = track_offset({req_ch.action, req_ch.millis_now, req_ch.server_epoch});
                results_due.push_back(due);
                cls_seen[due.sample_class]++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    nxt = req_backlog.pop_front();
                    items_popped++;
                    req_ch.valid <= 1'b1;
                    req_ch.action <= nxt.action;
                    req_ch.millis_now <= nxt.millis_now;
                    req_ch.server_epoch <= nxt.server_epoch;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result monitor: each accepted result against the oldest one owed.
    always @(posedge i_clk) begin
        coema_pkg::t_result due;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                flag_mismatch("result with none owed", res_ch.synced_time, 64'd0);
            end else begin
                due = results_due.pop_front();
                if (res_ch.synced_time !== due.synced_time) begin
                    flag_mismatch("synced_time", res_ch.synced_time, due.synced_time);
                end
                if (res_ch.sample_class !== due.sample_class) begin
                    flag_mismatch("sample_class", 64'(res_ch.sample_class),
                                  64'(due.sample_class));
                end
                if (res_ch.is_synced !== due.is_synced) begin
                    flag_mismatch("is_synced", 64'(res_ch.is_synced), 64'(due.is_synced));
                end
            end
        end
    end

    // Waits until every queued request has been answered.
    task automatic settle();
        while (req_backlog.size() != 0 || results_seen < items_popped) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(coema_pkg::t_cfg_index idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        case (idx)
            coema_pkg::CFG_THRESHOLD: filt_cfg.threshold = val;
            coema_pkg::CFG_LIMIT:     filt_cfg.limit = val[7:0];
            coema_pkg::CFG_SHIFT:     filt_cfg.shift = val[4:0];
            default: ;
        endcase
        writes_done++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_item(logic act, logic [31:0] ms, logic [63:0] ep);
        coema_pkg::t_item it;
        it.action = act;
        it.millis_now = ms;
        it.server_epoch = ep;
        req_backlog.push_back(it);
    endtask

    // Sends a server message whose sample lies exactly diff away from the
    // current offset; the filter is drained first so the offset is known.
    task automatic aim_sample(logic [31:0] ms, logic [63:0] diff);
        logic [31:0] wr;
        settle();
        wr = (ms < prev_millis) ? wraps + 32'd1 : wraps;
        push_item(1'b1, ms, filt_offset + diff + {wr, ms});
    endtask

    // Random requests: mostly a steadily advancing counter with server
    // messages near the true offset, plus outliers, offset steps and noise.
    task automatic queue_random(int count);
        coema_pkg::t_item   it;
        logic [63:0]        stamp;
        logic [63:0]        noise;
        logic [63:0]        big;
        logic [31:0]        span;
        logic signed [63:0] jump;
        int                 pick;
        int                 k;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                it.millis_now = gen_millis + $urandom_range(50);
            end else if (pick < 80) begin
                it.millis_now = gen_millis + $urandom_range(1 << 20);
            end else if (pick < 88) begin
                it.millis_now = $urandom;
            end else if (pick < 93) begin
                it.millis_now = gen_millis;
            end else begin
                it.millis_now = 32'hFFFF_FFFF - $urandom_range(100);
            end
            if (it.millis_now < gen_millis) begin
                gen_wraps = gen_wraps + 32'd1;
            end
            gen_millis = it.millis_now;
            stamp = {gen_wraps, gen_millis};
            it.action = ($urandom_range(99) < 75);

            span = (gen_thr > 32'd4000) ? 32'd4000 : gen_thr;
            noise = 64'($urandom_range(span));
            if ($urandom_range(1)) begin
                noise = -noise;
            end
            big = {32'd0, gen_thr} + 64'd1 + 64'($urandom_range(1_000_000));
            pick = $urandom_range(99);
            if (pick < 60) begin
                it.server_epoch = gen_true + stamp + noise;
            end else if (pick < 75) begin
                it.server_epoch = gen_true + stamp + ($urandom_range(1) ? big : -big);
            end else if (pick < 80) begin
                it.server_epoch = {$urandom, $urandom};
            end else if (pick < 88) begin
                // Step in the server clock: outliers until the filter resyncs.
                jump = {$urandom, $urandom};
                jump = jump >>> 24;
                gen_true = gen_true + jump;
                it.server_epoch = gen_true + stamp + noise;
            end else begin
                case ($urandom_range(3))
                    0: it.server_epoch = 64'h7FFF_FFFF_FFFF_FFFF;
                    1: it.server_epoch = 64'h8000_0000_0000_0000;
                    2: it.server_epoch = 64'd0;
                    default: it.server_epoch = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            req_backlog.push_back(it);
        end
    endtask

    // One setting of the registers and of the idling, then random requests.
    task automatic run_phase(logic [31:0] thr, logic [7:0] lim, logic [4:0] shf,
                             int send_gap, int recv_stall, int count, bit pause_mid);
        settle();
        repeat (4) @(posedge i_clk);
        write_reg(coema_pkg::CFG_THRESHOLD, thr);
        write_reg(coema_pkg::CFG_LIMIT, {24'd0, lim});
        write_reg(coema_pkg::CFG_SHIFT, {27'd0, shf});
        gen_thr = thr;
        gen_millis = prev_millis;
        gen_wraps = wraps;
        gen_true = filt_offset;
        gap_pct = send_gap;
        stall_pct = recv_stall;
        if (pause_mid) begin
            queue_random(count / 2);
            settle();
            queue_random(count - count / 2);
        end else begin
            queue_random(count);
        end
    endtask

    // Main sequence.
    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = 1'b0;
        req_ch.millis_now = '0;
        req_ch.server_epoch = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = coema_pkg::CFG_THRESHOLD;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        filt_cfg = {coema_pkg::ThresholdReset, coema_pkg::LimitReset, coema_pkg::ShiftReset};
        prev_millis = '0;
        wraps = '0;
        filt_offset = '0;
        locked = 1'b0;
        miss_run = '0;
        foreach (cls_seen[c]) cls_seen[c] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries before sync, counter wrap and equal readings.
        push_item(1'b0, 32'd0, 64'd0);
        push_item(1'b0, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        push_item(1'b0, 32'd5, 64'h8000_0000_0000_0000);
        push_item(1'b0, 32'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        // First sync, then smoothing with floor rounding on both sides.
        push_item(1'b1, 32'd100, 64'd1_700_000_000_000);
        aim_sample(32'd110, 64'd7);
        aim_sample(32'd120, -64'd1);
        // Threshold edges: exactly at it is accepted, one beyond is not.
        aim_sample(32'd130, 64'd1000);
        aim_sample(32'd140, -64'd1000);
        aim_sample(32'd150, 64'd1001);
        aim_sample(32'd160, -64'd1001);
        // Most negative difference always counts as an outlier.
        aim_sample(32'd170, 64'h8000_0000_0000_0000);
        push_item(1'b0, 32'd175, 64'd0);
        aim_sample(32'd180, 64'd5000);
        aim_sample(32'd190, 64'd5000);
        // Extreme server epochs, then an exact match and a wrapping query.
        push_item(1'b1, 32'd200, 64'h7FFF_FFFF_FFFF_FFFF);
        push_item(1'b1, 32'd210, 64'h8000_0000_0000_0000);
        push_item(1'b1, 32'd220, 64'd0);
        aim_sample(32'd230, 64'd0);
        push_item(1'b0, 32'd0, 64'd0);

        // Random phases over the register extremes and idling patterns.
        run_phase(32'd1000, 8'd5, 5'd3, 0, 0, 120, 1'b0);
        run_phase(32'd0, 8'd1, 5'd0, 57, 0, 80, 1'b0);
        run_phase(32'hFFFF_FFFF, 8'd255, 5'd16, 0, 57, 80, 1'b0);
        // A limit of zero resyncs on every outlier; shift 31 is used as given.
        run_phase(32'd50, 8'd0, 5'd31, 27, 27, 80, 1'b0);
        run_phase(32'd5000, 8'd3, 5'd17, 0, 0, 120, 1'b1);
        run_phase($urandom_range(5000), 8'($urandom_range(1, 8)), 5'($urandom_range(16)),
                  $urandom_range(1) ? 57 : 27, $urandom_range(1) ? 57 : 27, 120, 1'b0);

        settle();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests and %0d register writes over six settings.",
                 items_popped, writes_done);
        $display("Classes: none %0d, first %0d, smoothed %0d, rejected %0d, resynced %0d.",
                 cls_seen[coema_pkg::CLS_NONE], cls_seen[coema_pkg::CLS_FIRST],
                 cls_seen[coema_pkg::CLS_SMOOTH], cls_seen[coema_pkg::CLS_REJECT],
                 cls_seen[coema_pkg::CLS_RESYNC]);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* clock_offset_ema_filter.f */
hdl/coema_pkg.sv
hdl/coema_req_if.sv
hdl/coema_res_if.sv
hdl/coema_cfg_if.sv
hdl/coema_cfg.sv
hdl/coema_filter.sv
hdl/clock_offset_ema_filter.sv
tb/tb_clock_offset_ema_filter.sv
